// ----- sv/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is asserted
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked assertion that also covers reset cycles
`define ASSERT_CLK_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- sv/sdsc_pkg.sv -----
// shared types and constants of the surround downmix with soft clip
`default_nettype none
package sdsc_pkg;

    localparam int VW        = 23;   // signed Q.16 downmix value before scaling
    localparam int SCALE_W   = 24;   // unsigned Q8.16 mono scale
    localparam int PW        = VW + SCALE_W + 1;
    localparam int WSUM_W    = 19;   // sum of eight Q2.14 weights
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 64;

    localparam logic [SCALE_W-1:0] SCALE_ONE = SCALE_W'(65536);
    localparam logic [SCALE_W-1:0] SCALE_MAX = {SCALE_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] REG_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_W_LOW   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_W_HIGH  = 2'd2;

    localparam logic [CFG_W-1:0] WEIGHTS_RESET = 64'h4000_4000_4000_4000;

    typedef struct packed {
        logic mono;
        logic last;
    } t_ctl;

    typedef struct packed {
        logic                busy;
        logic [SCALE_W-1:0]  scale;
    } t_div_stat;

endpackage
`default_nettype wire

// ----- sv/sdsc_lane.sv -----
// one channel lane: sample times channel coefficient, registered
`default_nettype none
module sdsc_lane #(
    parameter int SAMPLE_BITS = 16,
    parameter int CW          = 16
) (
    input  wire                                i_clk,
    input  wire                                i_en,
    input  wire  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  wire  logic        [CW-1:0]          i_coef,
    output logic signed [SAMPLE_BITS+CW:0]      o_prod
);

    logic signed [SAMPLE_BITS+CW:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_sample * $signed({1'b0, i_coef});
        end
    end

    assign o_prod = r_prod;

endmodule
`default_nettype wire

// ----- sv/sdsc_merge.sv -----
// merge of the lane products into left and right, rounding and mono scaling
`default_nettype none
module sdsc_merge
    import sdsc_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int PRW         = 33
) (
    input  wire                       i_clk,
    input  wire                       i_en,
    input  wire  t_ctl                i_ctl1,
    input  wire  t_ctl                i_ctl2,
    input  wire  logic signed [PRW-1:0] i_prod [8],
    input  wire  logic [SCALE_W-1:0]  i_scale,
    output logic signed [PW-1:0]      o_p_l,
    output logic signed [PW-1:0]      o_p_r
);

    localparam int SUMW = PRW + 3;
    localparam int SH_M = SAMPLE_BITS - 3;
    // stereo sum carries twice the sample fraction, brought down to q.16
    localparam int SH_S = 2 * SAMPLE_BITS - 18;

    logic signed [SUMW-1:0] all_sum, l_sum, r_sum, sel_l, sel_r, rl, rr;
    logic signed [VW-1:0]   r_v_l, r_v_r;
    logic signed [PW-1:0]   r_p_l, r_p_r;
    logic signed [SCALE_W:0] scale_s;

    always_comb begin
        all_sum = '0;
        for (int c = 0; c < 8; c++) begin
            all_sum = all_sum + SUMW'(i_prod[c]);
        end
        l_sum = SUMW'(i_prod[0]) + SUMW'(i_prod[2]) + SUMW'(i_prod[4]) + SUMW'(i_prod[6]);
        r_sum = SUMW'(i_prod[1]) + SUMW'(i_prod[2]) + SUMW'(i_prod[5]) + SUMW'(i_prod[7]);
        sel_l = i_ctl1.mono ? all_sum : l_sum;
        sel_r = i_ctl1.mono ? all_sum : r_sum;
        // round to nearest, ties up
        if (i_ctl1.mono) begin
            rl = (sel_l + (SUMW'(1) <<< (SH_M - 1))) >>> SH_M;
            rr = (sel_r + (SUMW'(1) <<< (SH_M - 1))) >>> SH_M;
        end else begin
            rl = (sel_l + (SUMW'(1) <<< (SH_S - 1))) >>> SH_S;
            rr = (sel_r + (SUMW'(1) <<< (SH_S - 1))) >>> SH_S;
        end
    end

    assign scale_s = $signed({1'b0, i_scale});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v_l <= rl[VW-1:0];
            r_v_r <= rr[VW-1:0];
            if (i_ctl2.mono) begin
                r_p_l <= PW'(r_v_l * scale_s);
                r_p_r <= PW'(r_v_r * scale_s);
            end else begin
                r_p_l <= PW'(r_v_l) <<< 16;
                r_p_r <= PW'(r_v_r) <<< 16;
            end
        end
    end

    assign o_p_l = r_p_l;
    assign o_p_r = r_p_r;

endmodule
`default_nettype wire

// ----- sv/sdsc_div.sv -----
// restoring divider for the mono scale, one quotient bit per cycle
`default_nettype none
module sdsc_div
    import sdsc_pkg::*;
(
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_start,
    input  wire  logic [WSUM_W-1:0] i_wsum,
    output t_div_stat               o_stat
);

    localparam int QW = 34;
    localparam int RW = WSUM_W + 1;

    typedef enum logic [1:0] {S_IDLE, S_LOAD, S_RUN} t_state;

    t_state              r_state;
    logic [WSUM_W-1:0]   r_den;
    logic [QW-1:0]       r_num;
    logic [QW-1:0]       r_q;
    logic [RW-1:0]       r_rem;
    logic [5:0]          r_cnt;
    logic [SCALE_W-1:0]  r_scale;

    logic [RW:0]         trial;
    logic                fits;
    logic [RW-1:0]       n_rem;
    logic [QW-1:0]       n_q;

    always_comb begin
        trial = {r_rem, r_num[QW-1]};
        fits  = trial >= (RW+1)'(r_den);
        n_rem = fits ? RW'(trial - (RW+1)'(r_den)) : trial[RW-1:0];
        n_q   = {r_q[QW-2:0], fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_scale <= SCALE_ONE;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) r_state <= S_LOAD;
                end
                S_LOAD: begin
                    if (i_wsum == '0) begin
                        r_scale <= SCALE_ONE;
                        r_state <= S_IDLE;
                    end else begin
                        r_den   <= i_wsum;
                        r_num   <= (QW'(1) << 33) + QW'(i_wsum >> 1);
                        r_q     <= '0;
                        r_rem   <= '0;
                        r_cnt   <= 6'(QW);
                        r_state <= S_RUN;
                    end
                    // a write landing now changes the sum again, load once more
                    if (i_start) r_state <= S_LOAD;
                end
                S_RUN: begin
                    r_rem <= n_rem;
                    r_q   <= n_q;
                    r_num <= r_num << 1;
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == 6'd1) begin
                        r_scale <= (n_q > QW'(SCALE_MAX)) ? SCALE_MAX : n_q[SCALE_W-1:0];
                        r_state <= i_start ? S_LOAD : S_IDLE;
                    end else if (i_start) begin
                        r_state <= S_LOAD;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign o_stat.busy  = (r_state != S_IDLE);
    assign o_stat.scale = r_scale;

endmodule
`default_nettype wire

// ----- sv/sdsc_clip.sv -----
// tanh soft clip lane: table lookup with linear interpolation, two stages
`default_nettype none
module sdsc_clip
    import sdsc_pkg::*;
#(
    parameter int SAMPLE_BITS        = 16,
    parameter int CLIP_TABLE_ENTRIES = 1024
) (
    input  wire                          i_clk,
    input  wire                          i_en,
    input  wire  logic signed [PW-1:0]   i_p,
    output logic signed [SAMPLE_BITS-1:0] o_y
);

    localparam int FRAC = SAMPLE_BITS - 1;
    localparam int XW   = PW - 16;
    localparam int KW   = $clog2(CLIP_TABLE_ENTRIES + 1);
    localparam int NW   = $clog2(CLIP_TABLE_ENTRIES) + 1;
    localparam int POSW = 20 + NW;

    typedef logic [FRAC-1:0] t_tbl [CLIP_TABLE_ENTRIES+1];

    // shift and subtract quotient, used only while the table is built
    function automatic longint unsigned div_u64(longint unsigned nu, longint unsigned dv);
        longint unsigned q, r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], nu[b]};
            if (r >= dv) begin
                r    = r - dv;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic t_tbl build_tbl();
        t_tbl              tb;
        longint unsigned   t, term, e, num, den, v;
        longint            sm;
        for (int i = 0; i <= CLIP_TABLE_ENTRIES; i++) begin
            t    = div_u64(longint'(i) << 30, longint'(CLIP_TABLE_ENTRIES));
            sm   = longint'(1) << 30;
            term = longint'(1) << 30;
            for (int n = 1; n <= 18; n++) begin
                term = ((term * t) + (64'd1 << 29)) >> 30;
                term = div_u64(term + longint'(n / 2), longint'(n));
                if (n % 2 == 1) sm = sm - longint'(term);
                else sm = sm + longint'(term);
            end
            if (sm < 0) sm = 0;
            e = longint'(sm);
            for (int k = 0; k < 4; k++) e = (e * e + (64'd1 << 29)) >> 30;
            if (e > (64'd1 << 30)) e = 64'd1 << 30;
            num = (64'd1 << 30) - e;
            den = (64'd1 << 30) + e;
            v = div_u64((num << FRAC) + (den >> 1), den);
            if (v > (64'd1 << FRAC) - 1) v = (64'd1 << FRAC) - 1;
            tb[i] = v[FRAC-1:0];
        end
        return tb;
    endfunction

    localparam t_tbl TBL = build_tbl();

    logic signed [PW-1:0] xr;
    logic signed [XW-1:0] x;
    logic                 neg;
    logic [XW-1:0]        a_full;
    logic [19:0]          a;
    logic [POSW-1:0]      pos;
    logic [POSW-20:0]     k_full;
    logic [KW-1:0]        k0, k1;
    logic [18:0]          f;

    logic [FRAC-1:0]      r_t0, r_t1;
    logic [18:0]          r_f;
    logic                 r_neg;
    logic signed [SAMPLE_BITS-1:0] r_y;

    logic [FRAC-1:0]      d;
    logic [FRAC+19:0]     prod;
    logic [FRAC:0]        y;

    always_comb begin
        xr     = (i_p + PW'(32768)) >>> 16;
        x      = xr[XW-1:0];
        neg    = x[XW-1];
        a_full = neg ? XW'(-x) : XW'(x);
        a      = (a_full > XW'(1 << 19)) ? 20'(1 << 19) : a_full[19:0];
        pos    = POSW'(a) * POSW'(CLIP_TABLE_ENTRIES);
        k_full = pos[POSW-1:19];
        if (k_full >= (POSW-19)'(CLIP_TABLE_ENTRIES)) begin
            k0 = KW'(CLIP_TABLE_ENTRIES);
            k1 = KW'(CLIP_TABLE_ENTRIES);
            f  = '0;
        end else begin
            k0 = k_full[KW-1:0];
            k1 = k_full[KW-1:0] + KW'(1);
            f  = pos[18:0];
        end
    end

    always_comb begin
        d    = r_t1 - r_t0;
        prod = (FRAC+20)'(d) * (FRAC+20)'(r_f) + (FRAC+20)'(1 << 18);
        y    = (FRAC+1)'(r_t0) + (FRAC+1)'(prod >> 19);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t0  <= TBL[k0];
            r_t1  <= TBL[k1];
            r_f   <= f;
            r_neg <= neg;
            r_y   <= r_neg ? -$signed(SAMPLE_BITS'(y)) : $signed(SAMPLE_BITS'(y));
        end
    end

    assign o_y = r_y;

endmodule
`default_nettype wire

// ----- sv/surround_downmix_soft_clip.sv -----
// 7.1 to stereo downmix with tanh soft clip: lanes, merge, clip, scale divider
// throughput: one item per cycle while the scale divider is idle and the output is taken;
// all stages advance together behind the output register
// after reset and after each configuration write the mono scale divider runs a load step
// and then works out its 34 quotient bits, and no item is accepted meanwhile
// reset is synchronous and active low; it clears the pipeline and restores the registers
`default_nettype none
module surround_downmix_soft_clip
    import sdsc_pkg::*;
#(
    parameter int SAMPLE_BITS        = 16,
    parameter int CLIP_TABLE_ENTRIES = 1024
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // configuration write port
    input  wire                               i_cfg_we,
    input  wire  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  wire  logic [CFG_W-1:0]            i_cfg_data,
    // input frame
    input  wire                               i_in_valid,
    output logic                              o_in_ready,
    input  wire  logic signed [SAMPLE_BITS-1:0] i_front_left,
    input  wire  logic signed [SAMPLE_BITS-1:0] i_front_right,
    input  wire  logic signed [SAMPLE_BITS-1:0] i_center,
    input  wire  logic signed [SAMPLE_BITS-1:0] i_low_freq,
    input  wire  logic signed [SAMPLE_BITS-1:0] i_back_left,
    input  wire  logic signed [SAMPLE_BITS-1:0] i_back_right,
    input  wire  logic signed [SAMPLE_BITS-1:0] i_side_left,
    input  wire  logic signed [SAMPLE_BITS-1:0] i_side_right,
    input  wire                               i_last_frame,
    // output pair
    output logic                              o_out_valid,
    input  wire                               i_out_ready,
    output logic signed [SAMPLE_BITS-1:0]     o_left_out,
    output logic signed [SAMPLE_BITS-1:0]     o_right_out,
    output logic                              o_last_out
);

    localparam int FRAC = SAMPLE_BITS - 1;
    localparam int CW   = (SAMPLE_BITS > 16) ? SAMPLE_BITS : 16;
    localparam int PRW  = SAMPLE_BITS + CW + 1;
    // 0.7071 in the sample format, rounded
    localparam longint ATT_GAIN_L = ((64'd7071 << FRAC) + 64'd5000) / 64'd10000;
    localparam logic [CW-1:0] ATT_GAIN = CW'(ATT_GAIN_L);
    localparam logic [CW-1:0] UNITY    = CW'(64'd1 << FRAC);

    // configuration registers
    logic             r_mode;
    logic [CFG_W-1:0] r_w_low, r_w_high;

    // pipeline control: valid and side info per stage
    logic [5:1] r_vld;
    t_ctl       r_ctl [1:5];
    logic       en, in_acc;

    t_div_stat          div_stat;
    logic [WSUM_W-1:0]  wsum;

    logic signed [SAMPLE_BITS-1:0] samples [8];
    logic [CW-1:0]                 coef    [8];
    logic signed [PRW-1:0]         prod    [8];
    logic signed [PW-1:0]          p_l, p_r;

    // whole pipe moves unless a finished pair sits unclaimed
    assign en         = !r_vld[5] || i_out_ready;
    assign o_in_ready = en && !div_stat.busy;
    assign in_acc     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= 1'b1;
            r_w_low  <= WEIGHTS_RESET;
            r_w_high <= WEIGHTS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_MODE:   r_mode   <= i_cfg_data[0];
                REG_W_LOW:  r_w_low  <= i_cfg_data;
                REG_W_HIGH: r_w_high <= i_cfg_data;
                default:    ;  // unknown index ignored
            endcase
        end
    end

    // weight sum feeding the scale divider
    always_comb begin
        wsum = '0;
        for (int c = 0; c < 4; c++) begin
            wsum = wsum + WSUM_W'(r_w_low[16*c +: 16]) + WSUM_W'(r_w_high[16*c +: 16]);
        end
    end

    sdsc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cfg_we),
        .i_wsum  (wsum),
        .o_stat  (div_stat)
    );

    // channel order as in the frame
    assign samples[0] = i_front_left;
    assign samples[1] = i_front_right;
    assign samples[2] = i_center;
    assign samples[3] = i_low_freq;
    assign samples[4] = i_back_left;
    assign samples[5] = i_back_right;
    assign samples[6] = i_side_left;
    assign samples[7] = i_side_right;

    // per channel gain: mono weight, or unity for fronts, 0.7071 for the rest, lfe dropped
    always_comb begin
        for (int c = 0; c < 8; c++) begin
            if (!r_mode) begin
                coef[c] = (c < 4) ? CW'(r_w_low[16*(c%4) +: 16]) : CW'(r_w_high[16*(c%4) +: 16]);
            end else if (c < 2) begin
                coef[c] = UNITY;
            end else if (c == 3) begin
                coef[c] = '0;
            end else begin
                coef[c] = ATT_GAIN;
            end
        end
    end

    for (genvar g = 0; g < 8; g++) begin : g_lane
        sdsc_lane #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .CW          (CW)
        ) u_lane (
            .i_clk    (i_clk),
            .i_en     (en),
            .i_sample (samples[g]),
            .i_coef   (coef[g]),
            .o_prod   (prod[g])
        );
    end

    // stages 2 and 3: channel sums, rounding, mono scale
    sdsc_merge #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .PRW         (PRW)
    ) u_merge (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_ctl1  (r_ctl[1]),
        .i_ctl2  (r_ctl[2]),
        .i_prod  (prod),
        .i_scale (div_stat.scale),
        .o_p_l   (p_l),
        .o_p_r   (p_r)
    );

    // stages 4 and 5: soft clip per side, stage 5 is the output register
    sdsc_clip #(
        .SAMPLE_BITS        (SAMPLE_BITS),
        .CLIP_TABLE_ENTRIES (CLIP_TABLE_ENTRIES)
    ) u_clip_l (
        .i_clk (i_clk),
        .i_en  (en),
        .i_p   (p_l),
        .o_y   (o_left_out)
    );

    sdsc_clip #(
        .SAMPLE_BITS        (SAMPLE_BITS),
        .CLIP_TABLE_ENTRIES (CLIP_TABLE_ENTRIES)
    ) u_clip_r (
        .i_clk (i_clk),
        .i_en  (en),
        .i_p   (p_r),
        .o_y   (o_right_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[4:1], in_acc};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ctl[1] <= '{mono: !r_mode, last: i_last_frame};
            for (int s = 2; s <= 5; s++) r_ctl[s] <= r_ctl[s-1];
        end
    end

    assign o_out_valid = r_vld[5];
    assign o_last_out  = r_ctl[5].last;

endmodule
`default_nettype wire

// ----- sv/sdsc_checker.sv -----
// port level checks of the downmix block and their binding
`default_nettype none
`include "assert_macros.svh"
module sdsc_checker
    import sdsc_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
) (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          i_cfg_we,
    input wire                          o_in_ready,
    input wire                          o_out_valid,
    input wire                          i_out_ready,
    input wire  logic [SAMPLE_BITS-1:0] o_left_out,
    input wire  logic [SAMPLE_BITS-1:0] o_right_out,
    input wire                          o_last_out
);

    // scale divider runs after reset, so nothing is taken or shown
    `ASSERT_CLK_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> (!o_in_ready && !o_out_valid), "busy after reset expected")

    // a register write restarts the scale divider
    `ASSERT_CLK(a_cfg_busy, i_clk, i_rst_n, i_cfg_we |=> !o_in_ready, "item taken during scale update")

    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, (o_out_valid && !i_out_ready) |=> o_out_valid, "output item dropped")

    `ASSERT_CLK(a_out_stable, i_clk, i_rst_n, (o_out_valid && !i_out_ready) |=> ($stable(o_left_out) && $stable(o_right_out) && $stable(o_last_out)), "stalled item changed")

endmodule

bind surround_downmix_soft_clip sdsc_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_sdsc_checker (.*);
`default_nettype wire
